// ===== rtl/pidd_pkg.sv =====
// Shared constants, register indexes and saturation helper for the PID delta unit.
package pidd_pkg;

  localparam int DATA_W    = 32;                  // Q16.16 data word
  localparam int FRAC_BITS = 16;                  // fraction bits of every Q value
  localparam int LIM_W     = DATA_W - 1;          // unsigned bounds and limits
  localparam int WIDE_W    = 2 * DATA_W - FRAC_BITS;  // product after the fraction shift
  localparam int IDX_W     = 4;                   // config index width
  localparam int ACC_W     = DATA_W + 4;          // exact sum of up to four data words

  // Config register indexes
  localparam logic [IDX_W-1:0] REG_CONTROL_MODE   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PROP_GAIN      = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_INTEGRAL_BOUND = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT   = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_ERROR_GATE     = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_DEAD_BAND      = IDX_W'(7);

  // Control modes
  localparam logic MODE_POSITIONAL  = 1'b0;
  localparam logic MODE_INCREMENTAL = 1'b1;

  // Saturate a wide signed value to the data word.
  function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-DATA_W:0] top;
    top = v[WIDE_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/pidd_gain_mult.sv =====
// Two-stage gain multiplier: signed product, floor shift by the fraction bits, saturate.
module pidd_gain_mult (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [pidd_pkg::DATA_W-1:0]   gain,
  input  logic signed [pidd_pkg::DATA_W-1:0]   operand,
  output logic signed [pidd_pkg::DATA_W-1:0]   result
);

  logic signed [2*pidd_pkg::DATA_W-1:0] product;

  // stage 1: exact product
  always_ff @(posedge clk) begin
    if (en) begin
      product <= (2*pidd_pkg::DATA_W)'(gain) * (2*pidd_pkg::DATA_W)'(operand);
    end
  end

  // stage 2: dropping the fraction bits of a two's complement value is a floor
  always_ff @(posedge clk) begin
    if (en) begin
      result <= pidd_pkg::sat_wide(product[2*pidd_pkg::DATA_W-1:pidd_pkg::FRAC_BITS]);
    end
  end

endmodule

// ===== rtl/pid_position_delta_unit.sv =====
// PID unit top: positional or incremental control step, one request per cycle unless stalled.
//
//  channel  | handshake                          | payload
//  ---------+------------------------------------+--------------------------------
//  sample   | sample_valid / sample_stall (in)   | measured, target (signed Q16.16)
//  result   | result_valid / result_stall (out)  | drive (signed Q16.16), gated
//  cfg      | cfg_valid / cfg_ready (in)         | cfg_index, cfg_data
//
// Throughput is one request per cycle while sample_stall is low. A request passes the
// input, error, operand, two multiplier stages, accumulate and output register on its
// way to result_valid, with the controller state kept inside its own stage.
// Reset (rst, synchronous) clears the pipeline, the history and the accumulators and
// loads the default config. A stalled result moves into a skid register; only when
// that is full does sample_stall rise, and the whole pipeline holds in place.
module pid_position_delta_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // sample channel
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic signed [pidd_pkg::DATA_W-1:0]   measured,
  input  logic signed [pidd_pkg::DATA_W-1:0]   target,
  // result channel
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [pidd_pkg::DATA_W-1:0]   drive,
  output logic                                 gated,
  // config write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pidd_pkg::IDX_W-1:0]           cfg_index,
  input  logic [pidd_pkg::DATA_W-1:0]          cfg_data
);

  localparam int DW = pidd_pkg::DATA_W;
  localparam int LW = pidd_pkg::LIM_W;
  localparam int WW = pidd_pkg::WIDE_W;
  localparam int AW = pidd_pkg::ACC_W;

  // ---------------------------------------------------------------------------
  // Config registers. The user must write only while the unit is drained; it is not enforced.
  // ---------------------------------------------------------------------------
  logic                 control_mode;
  logic signed [DW-1:0] prop_gain;
  logic signed [DW-1:0] integ_gain;
  logic signed [DW-1:0] deriv_gain;
  logic [LW-1:0]        integral_bound;
  logic [LW-1:0]        output_limit;
  logic [LW-1:0]        error_gate;
  logic [LW-1:0]        dead_band;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode   <= pidd_pkg::MODE_POSITIONAL;
      prop_gain      <= '0;
      integ_gain     <= '0;
      deriv_gain     <= '0;
      integral_bound <= '1;
      output_limit   <= '1;
      error_gate     <= '0;
      dead_band      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pidd_pkg::REG_CONTROL_MODE:   control_mode   <= cfg_data[0];
        pidd_pkg::REG_PROP_GAIN:      prop_gain      <= cfg_data;
        pidd_pkg::REG_INTEG_GAIN:     integ_gain     <= cfg_data;
        pidd_pkg::REG_DERIV_GAIN:     deriv_gain     <= cfg_data;
        pidd_pkg::REG_INTEGRAL_BOUND: integral_bound <= cfg_data[LW-1:0];
        pidd_pkg::REG_OUTPUT_LIMIT:   output_limit   <= cfg_data[LW-1:0];
        pidd_pkg::REG_ERROR_GATE:     error_gate     <= cfg_data[LW-1:0];
        pidd_pkg::REG_DEAD_BAND:      dead_band      <= cfg_data[LW-1:0];
        default: begin
          // unknown index: ignored
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: the pipeline moves as one while the skid register is empty.
  // ---------------------------------------------------------------------------
  logic skid_full;
  logic run;

  assign run          = !skid_full;
  assign sample_stall = skid_full;

  // valid and gated flags per stage
  logic a_valid, b_valid, c_valid, d_valid, e_valid, f_valid;
  logic b_gated, c_gated, d_gated, e_gated, f_gated;

  // ---------------------------------------------------------------------------
  // Stage A: input register
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] a_measured;
  logic signed [DW-1:0] a_target;

  always_ff @(posedge clk) begin
    if (run) begin
      a_measured <= measured;
      a_target   <= target;
    end
  end

  // error = sat(target - measured); gate compares |error| against error_gate
  logic signed [DW:0]   err_raw;
  logic signed [DW-1:0] err_sat;
  logic signed [DW:0]   gate_pos;
  logic                 err_gated;

  always_comb begin
    err_raw   = (DW+1)'(a_target) - (DW+1)'(a_measured);
    err_sat   = pidd_pkg::sat_wide(WW'(err_raw));
    gate_pos  = $signed({2'b00, error_gate});
    err_gated = (error_gate != '0) &&
                (((DW+1)'(err_sat) > gate_pos) || ((DW+1)'(err_sat) < -gate_pos));
  end

  // ---------------------------------------------------------------------------
  // Stage B: error register; error history lives here
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] b_error;
  logic signed [DW-1:0] last_error;
  logic signed [DW-1:0] earlier_error;

  always_ff @(posedge clk) begin
    if (run) begin
      b_error <= err_sat;
      b_gated <= err_gated;
    end
  end

  logic signed [WW-1:0] err_w;
  logic signed [WW-1:0] last_w;
  logic signed [DW-1:0] diff1;
  logic signed [DW-1:0] diff2;

  always_comb begin
    err_w  = WW'(b_error);
    last_w = WW'(last_error);
    diff1  = pidd_pkg::sat_wide(err_w - last_w);
    diff2  = pidd_pkg::sat_wide(err_w - (last_w <<< 1) + WW'(earlier_error));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error    <= '0;
      earlier_error <= '0;
    end else if (run && b_valid && !b_gated) begin
      earlier_error <= last_error;
      last_error    <= b_error;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: multiplier operands, picked by mode
  //   positional : P*e,  I*e, D*(e - last)
  //   incremental: P*(e - last), I*e, D*(e - 2*last + earlier)
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] c_xp;
  logic signed [DW-1:0] c_xi;
  logic signed [DW-1:0] c_xd;

  always_ff @(posedge clk) begin
    if (run) begin
      c_gated <= b_gated;
      c_xi    <= b_error;
      if (control_mode == pidd_pkg::MODE_INCREMENTAL) begin
        c_xp <= diff1;
        c_xd <= diff2;
      end else begin
        c_xp <= b_error;
        c_xd <= diff1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages D and E: three gain multipliers, two register stages each
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] term_p;
  logic signed [DW-1:0] term_i;
  logic signed [DW-1:0] term_d;

  pidd_gain_mult u_mult_p (
    .clk     (clk),
    .en      (run),
    .gain    (prop_gain),
    .operand (c_xp),
    .result  (term_p)
  );

  pidd_gain_mult u_mult_i (
    .clk     (clk),
    .en      (run),
    .gain    (integ_gain),
    .operand (c_xi),
    .result  (term_i)
  );

  pidd_gain_mult u_mult_d (
    .clk     (clk),
    .en      (run),
    .gain    (deriv_gain),
    .operand (c_xd),
    .result  (term_d)
  );

  always_ff @(posedge clk) begin
    if (run) begin
      d_gated <= c_gated;
      e_gated <= d_gated;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E accumulate: integral and output sums are state of this stage
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] integral_sum;
  logic signed [DW-1:0] output_sum;
  logic signed [DW-1:0] integral_sum_next;
  logic signed [DW-1:0] output_sum_next;

  function automatic logic signed [DW-1:0] clamp_sym(input logic signed [AW-1:0] v,
                                                     input logic [LW-1:0] bound);
    logic signed [AW-1:0] b;
    logic signed [AW-1:0] nb;
    b  = $signed({{(AW-LW){1'b0}}, bound});
    nb = -b;
    if (v > b) begin
      return b[DW-1:0];
    end else if (v < nb) begin
      return nb[DW-1:0];
    end else begin
      return v[DW-1:0];
    end
  endfunction

  always_comb begin
    if (control_mode == pidd_pkg::MODE_INCREMENTAL) begin
      // raw I increment is stored, not clamped
      integral_sum_next = term_i;
      output_sum_next   = clamp_sym(AW'(output_sum) + AW'(term_p) + AW'(term_i)
                                    + AW'(term_d), output_limit);
    end else begin
      integral_sum_next = clamp_sym(AW'(integral_sum) + AW'(term_i), integral_bound);
      output_sum_next   = clamp_sym(AW'(term_p) + AW'(integral_sum_next) + AW'(term_d),
                                    output_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      output_sum   <= '0;
    end else if (run && e_valid && !e_gated) begin
      integral_sum <= integral_sum_next;
      output_sum   <= output_sum_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: clamped output, then dead band and gate on the way out
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] f_sum;

  always_ff @(posedge clk) begin
    if (run) begin
      f_gated <= e_gated;
      f_sum   <= output_sum_next;
    end
  end

  logic signed [DW:0]   band_pos;
  logic                 in_band;
  logic signed [DW-1:0] res_drive;

  always_comb begin
    band_pos = $signed({2'b00, dead_band});
    in_band  = (dead_band != '0) &&
               ((DW+1)'(f_sum) < band_pos) && ((DW+1)'(f_sum) > -band_pos);
    if (f_gated || in_band) begin
      res_drive = '0;
    end else begin
      res_drive = f_sum;
    end
  end

  // stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
    end else if (run) begin
      a_valid <= sample_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      d_valid <= c_valid;
      e_valid <= d_valid;
      f_valid <= e_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid register
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0] skid_drive;
  logic                 skid_gated;
  logic                 out_take;

  assign out_take = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (skid_full) begin
      if (out_take) begin
        skid_full <= 1'b0;
      end
    end else if (f_valid) begin
      if (!result_valid || out_take) begin
        result_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_take) begin
        drive <= skid_drive;
        gated <= skid_gated;
      end
    end else if (f_valid) begin
      if (!result_valid || out_take) begin
        drive <= res_drive;
        gated <= f_gated;
      end else begin
        skid_drive <= res_drive;
        skid_gated <= f_gated;
      end
    end
  end

endmodule

// ===== rtl/pidd_checker.sv =====
// Port-level checks for the PID unit, bound to the top level.
module pidd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               sample_stall,
  input logic                               result_valid,
  input logic                               result_stall,
  input logic signed [pidd_pkg::DATA_W-1:0] drive,
  input logic                               gated
);

  // no result survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // a gated request always reads zero
  a_gated_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && gated |-> drive == '0)
    else $error("gated result with nonzero drive");

  // back-pressure on samples only once a result is waiting and was stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid && $past(result_stall))
    else $error("sample_stall without a stalled result");

  // stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(drive) && $stable(gated))
    else $error("stalled result changed");

endmodule

bind pid_position_delta_unit pidd_checker u_pidd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .drive        (drive),
  .gated        (gated)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the positional/incremental PID unit with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import pidd_pkg::*;

  localparam longint WORD_MAX   = (longint'(1) <<< (DATA_W - 1)) - 1;
  localparam longint WORD_MIN   = -WORD_MAX - 1;
  localparam int     IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int     PHASES     = 8;     // random register settings
  localparam int     PER_PHASE  = 200;   // requests per random setting

  // One expected output request.
  typedef struct {
    logic signed [DATA_W-1:0] drive;
    logic                     gated;
  } drive_rec_t;

  // Scoreboard: mirrors the controller state and config, queues the expected
  // drive for every accepted sample and checks results in order.
  class drive_scoreboard;
    bit         mode;
    longint     kp, ki, kd;
    longint     integ_bound, out_limit, err_gate, dband;
    longint     last_err, prior_err, integ_acc, out_acc;
    drive_rec_t expected_q[$];
    int         mismatches;
    int         requests;
    int         gated_count;
    int         deadband_hits;

    function new();
      mode        = MODE_POSITIONAL;
      kp          = 0;
      ki          = 0;
      kd          = 0;
      integ_bound = WORD_MAX;
      out_limit   = WORD_MAX;
      err_gate    = 0;
      dband       = 0;
      last_err    = 0;
      prior_err   = 0;
      integ_acc   = 0;
      out_acc     = 0;
      mismatches  = 0;
      requests    = 0;
      gated_count = 0;
      deadband_hits = 0;
    endfunction

    function longint sat_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
    endfunction

    function longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // gain * x in Q16.16: exact product, floor shift, saturate to a word
    function longint qmul(longint a, longint b);
      longint prod;
      prod = a * b;
      return sat_word(prod >>> FRAC_BITS);
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_CONTROL_MODE:   mode        = data[0];
        REG_PROP_GAIN:      kp          = longint'(signed'(data));
        REG_INTEG_GAIN:     ki          = longint'(signed'(data));
        REG_DERIV_GAIN:     kd          = longint'(signed'(data));
        REG_INTEGRAL_BOUND: integ_bound = longint'(data[LIM_W-1:0]);
        REG_OUTPUT_LIMIT:   out_limit   = longint'(data[LIM_W-1:0]);
        REG_ERROR_GATE:     err_gate    = longint'(data[LIM_W-1:0]);
        REG_DEAD_BAND:      dband       = longint'(data[LIM_W-1:0]);
        default: ;  // unknown index: dropped
      endcase
    endfunction

    function void take_sample(logic signed [DATA_W-1:0] meas, logic signed [DATA_W-1:0] tgt);
      longint     err, p, i, d, outv;
      drive_rec_t rec;
      requests++;
      err = sat_word(longint'(tgt) - longint'(meas));
      // error beyond the gate: zero output, flag set, state frozen
      if (err_gate != 0 && magnitude(err) > err_gate) begin
        rec.drive = '0;
        rec.gated = 1'b1;
        gated_count++;
        expected_q.push_back(rec);
        return;
      end
      if (mode == MODE_POSITIONAL) begin
        p         = qmul(kp, err);
        integ_acc = clamp_sym(integ_acc + qmul(ki, err), integ_bound);
        d         = qmul(kd, sat_word(err - last_err));
        out_acc   = clamp_sym(p + integ_acc + d, out_limit);
      end else begin
        p         = qmul(kp, sat_word(err - last_err));
        i         = qmul(ki, err);
        d         = qmul(kd, sat_word(err - 2 * last_err + prior_err));
        integ_acc = i;  // raw increment, no clamp in this mode
        out_acc   = clamp_sym(out_acc + p + i + d, out_limit);
      end
      prior_err = last_err;
      last_err  = err;
      outv = out_acc;
      if (dband != 0 && magnitude(outv) < dband) begin
        outv = 0;
        deadband_hits++;
      end
      rec.drive = outv[DATA_W-1:0];
      rec.gated = 1'b0;
      expected_q.push_back(rec);
    endfunction

    function void check_drive(logic signed [DATA_W-1:0] act_drive, logic act_gated);
      drive_rec_t want;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: drive %0d gated %0b", act_drive, act_gated);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (act_drive !== want.drive) begin
        $error("drive: expected %0d, got %0d", want.drive, act_drive);
        mismatches++;
      end
      if (act_gated !== want.gated) begin
        $error("gated: expected %0b, got %0b", want.gated, act_gated);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // DUT ports
  logic                     clk = 1'b0;
  logic                     rst;
  logic                     sample_valid;
  logic                     sample_stall;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] target;
  logic                     result_valid;
  logic                     result_stall;
  logic signed [DATA_W-1:0] drive;
  logic                     gated;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index;
  logic [DATA_W-1:0]        cfg_data;

  drive_scoreboard sb = new();

  // Handshake counters, bumped by the monitor at the rising edge and polled by
  // the drivers at the falling edge.
  int samples_taken = 0;
  int results_taken = 0;
  int cfg_writes    = 0;
  int idle_cycles   = 0;
  int settings_used = 0;

  // Per-phase idling switches; set means that side runs flat out.
  bit calm_send = 1'b0;
  bit calm_recv = 1'b0;

  logic [DATA_W-1:0] cfg_plan [REG_CONTROL_MODE:REG_DEAD_BAND];

  pid_position_delta_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .measured     (measured),
    .target       (target),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .drive        (drive),
    .gated        (gated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Monitor: inputs only move on the falling edge and the DUT updates on the
  // rising edge, so the values seen here are the ones the handshake used.
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        sb.take_sample(measured, target);
        samples_taken++;
        moved = 1'b1;
      end
      if (result_valid && !result_stall) begin
        sb.check_drive(drive, gated);
        results_taken++;
        moved = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.write_reg(cfg_index, cfg_data);
        cfg_writes++;
        moved = 1'b1;
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: a stuck handshake ends the run.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $error("no handshake for %0d cycles, %0d results outstanding", IDLE_LIMIT, sb.pending());
    $display("simulation failed");
    $finish;
  end

  // Result side: per result, hold stall for a random while unless calm_recv is set, then take it.
  initial begin
    int hold, start;
    result_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = calm_recv ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        result_stall = 1'b1;
        repeat (hold) @(negedge clk);
        result_stall = 1'b0;
      end
      start = results_taken;
      while (results_taken == start) @(negedge clk);
    end
  end

  // Small signed value in [-span, span].
  function automatic logic [DATA_W-1:0] near(int span);
    return DATA_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end else if (r <= 2) begin
      return $urandom();
    end
    return near(span);
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      case ($urandom_range(0, 2))
        0:       return 32'h0000_0000;
        1:       return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end else if (r == 1) begin
      return $urandom();
    end
    return near(32'h0003_0000);
  endfunction

  // Unsigned bound; bit 31 is junk that the register must drop.
  function automatic logic [DATA_W-1:0] pick_bound(int typical);
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h0000_0000;
      1:       v = 32'h7FFF_FFFF;
      2:       v = $urandom();
      default: v = $urandom_range(0, typical);
    endcase
    v[DATA_W-1] = 1'($urandom_range(0, 1));
    return v;
  endfunction

  // Send one request; a random gap goes first unless calm_send is set.
  task automatic send_sample(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] t);
    int gap, start;
    gap = calm_send ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    measured     = m;
    target       = t;
    sample_valid = 1'b1;
    start        = samples_taken;
    @(negedge clk);
    while (samples_taken == start) @(negedge clk);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    sample_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // Write all eight registers from cfg_plan, optionally followed by a write to
  // an unused index that must change nothing.
  task automatic apply_plan(input bit with_stray);
    int start;
    cfg_valid = 1'b1;
    for (int r = REG_CONTROL_MODE; r <= REG_DEAD_BAND; r++) begin
      cfg_index = IDX_W'(r);
      cfg_data  = cfg_plan[r];
      start     = cfg_writes;
      @(negedge clk);
      while (cfg_writes == start) @(negedge clk);
    end
    if (with_stray) begin
      cfg_index = IDX_W'(REG_DEAD_BAND + 1 + $urandom_range(0, 7));
      cfg_data  = $urandom();
      start     = cfg_writes;
      @(negedge clk);
      while (cfg_writes == start) @(negedge clk);
    end
    cfg_valid = 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [DATA_W-1:0] m, t;
    int                span;
    rst          = 1'b1;
    sample_valid = 1'b0;
    measured     = '0;
    target       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: positional mode, error extremes that saturate the subtraction,
    // integral running into its bound.
    cfg_plan[REG_CONTROL_MODE]   = {31'd0, MODE_POSITIONAL};
    cfg_plan[REG_PROP_GAIN]      = 32'h0001_0000;
    cfg_plan[REG_INTEG_GAIN]     = 32'h0000_8000;
    cfg_plan[REG_DERIV_GAIN]     = 32'h0002_0000;
    cfg_plan[REG_INTEGRAL_BOUND] = 32'h0010_0000;
    cfg_plan[REG_OUTPUT_LIMIT]   = 32'h7FFF_FFFF;
    cfg_plan[REG_ERROR_GATE]     = 32'h0000_0000;
    cfg_plan[REG_DEAD_BAND]      = 32'h0000_0000;
    apply_plan(1'b0);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(32'h8000_0000, 32'h8000_0000);
    send_sample(32'h0000_0000, 32'h0000_0001);
    send_sample(32'h0000_0001, 32'h0000_0000);
    send_sample(32'h0001_2345, 32'hFFFF_9877);
    drain();

    // Directed: error gate at 1.0, dead band at 0.5, tight output limit.
    // Junk above the register widths must be dropped; stray index ignored.
    cfg_plan[REG_CONTROL_MODE]   = {31'h7FFF_FFFF, MODE_POSITIONAL};
    cfg_plan[REG_PROP_GAIN]      = 32'h0002_0000;
    cfg_plan[REG_INTEG_GAIN]     = 32'h0001_0000;
    cfg_plan[REG_DERIV_GAIN]     = 32'h0000_0000;
    cfg_plan[REG_INTEGRAL_BOUND] = 32'h8000_0000;
    cfg_plan[REG_OUTPUT_LIMIT]   = 32'h0004_0000;
    cfg_plan[REG_ERROR_GATE]     = 32'h8001_0000;
    cfg_plan[REG_DEAD_BAND]      = 32'h0000_8000;
    apply_plan(1'b1);
    send_sample(32'h0000_0000, 32'h0001_0001);  // just past the gate
    send_sample(32'h0000_0000, 32'h0001_0000);  // right at the gate
    send_sample(32'h0001_0001, 32'h0000_0000);  // past the gate, negative
    send_sample(32'h8000_0000, 32'h7FFF_FFFF);  // saturated error, gated
    send_sample(32'h0000_0000, 32'h0000_0100);  // inside the dead band
    send_sample(32'h0000_0000, 32'h0000_8000);
    send_sample(32'h0000_0000, 32'h0000_FFFF);
    drain();

    // Directed: incremental mode with extreme gains so large errors saturate the products.
    cfg_plan[REG_CONTROL_MODE]   = {31'd1, MODE_INCREMENTAL};
    cfg_plan[REG_PROP_GAIN]      = 32'h8000_0000;
    cfg_plan[REG_INTEG_GAIN]     = 32'h7FFF_FFFF;
    cfg_plan[REG_DERIV_GAIN]     = 32'h8000_0000;
    cfg_plan[REG_INTEGRAL_BOUND] = 32'h7FFF_FFFF;
    cfg_plan[REG_OUTPUT_LIMIT]   = 32'h7FFF_FFFF;
    cfg_plan[REG_ERROR_GATE]     = 32'h0000_0000;
    cfg_plan[REG_DEAD_BAND]      = 32'h0000_0000;
    apply_plan(1'b0);
    send_sample(32'h0000_0000, 32'h7FFF_FFFF);
    send_sample(32'h0000_0000, 32'h8000_0000);
    send_sample(32'h0000_0000, 32'h0000_0000);
    send_sample(32'h0000_0005, 32'hFFFF_FFFB);
    send_sample(32'h7FFF_FFFF, 32'h8000_0000);
    send_sample(32'h0001_0000, 32'h0001_0000);
    drain();

    // Random settings. The first two are the corners: all but the dead band at the top,
    // then gains at the negative end with zero bounds. Mode alternation carries
    // the integral over from one mode into the other.
    for (int k = 0; k < PHASES; k++) begin
      calm_send = (k % 3 == 1);
      calm_recv = (k % 4 == 2);
      if (k == 0) begin
        cfg_plan[REG_CONTROL_MODE]   = {31'd0, MODE_POSITIONAL};
        cfg_plan[REG_PROP_GAIN]      = 32'h7FFF_FFFF;
        cfg_plan[REG_INTEG_GAIN]     = 32'h7FFF_FFFF;
        cfg_plan[REG_DERIV_GAIN]     = 32'h7FFF_FFFF;
        cfg_plan[REG_INTEGRAL_BOUND] = 32'h7FFF_FFFF;
        cfg_plan[REG_OUTPUT_LIMIT]   = 32'h7FFF_FFFF;
        cfg_plan[REG_ERROR_GATE]     = 32'h7FFF_FFFF;
        cfg_plan[REG_DEAD_BAND]      = 32'h0000_0000;
      end else if (k == 1) begin
        cfg_plan[REG_CONTROL_MODE]   = {31'd0, MODE_INCREMENTAL};
        cfg_plan[REG_PROP_GAIN]      = 32'h8000_0000;
        cfg_plan[REG_INTEG_GAIN]     = 32'h8000_0000;
        cfg_plan[REG_DERIV_GAIN]     = 32'h8000_0000;
        cfg_plan[REG_INTEGRAL_BOUND] = 32'h0000_0000;
        cfg_plan[REG_OUTPUT_LIMIT]   = ($urandom_range(0, 1) != 0) ? 32'h0 : 32'h0000_0001;
        cfg_plan[REG_ERROR_GATE]     = 32'h0000_0000;
        cfg_plan[REG_DEAD_BAND]      = 32'h7FFF_FFFF;
      end else begin
        cfg_plan[REG_CONTROL_MODE]   = {31'($urandom()),
                                        ($urandom_range(0, 1) != 0) ? MODE_INCREMENTAL
                                                                     : MODE_POSITIONAL};
        cfg_plan[REG_PROP_GAIN]      = pick_gain();
        cfg_plan[REG_INTEG_GAIN]     = pick_gain();
        cfg_plan[REG_DERIV_GAIN]     = pick_gain();
        cfg_plan[REG_INTEGRAL_BOUND] = pick_bound(32'h0040_0000);
        cfg_plan[REG_OUTPUT_LIMIT]   = pick_bound(32'h0080_0000);
        cfg_plan[REG_ERROR_GATE]     = ($urandom_range(0, 1) != 0) ? 32'h0
                                                                   : pick_bound(32'h0008_0000);
        cfg_plan[REG_DEAD_BAND]      = ($urandom_range(0, 2) != 0) ? 32'h0
                                                                   : pick_bound(32'h0000_8000);
      end
      apply_plan($urandom_range(0, 1) != 0);

      // Mostly a set point tracking near the measurement, so the history and
      // integral stay meaningful; some fully random or extreme pairs.
      span = $urandom_range(32'h100, 32'h4_0000);
      for (int n = 0; n < PER_PHASE; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          m = pick_value(span);
          t = pick_value(span);
        end else begin
          m = near(32'h0004_0000);
          t = m + near(span);
        end
        send_sample(m, t);
      end
      drain();
    end

    // Let the pipeline settle so a stray late result would still be caught.
    repeat (12) @(negedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.mismatches++;
    end

    $display("covered %0d requests over %0d register settings in both control modes",
             sb.requests, settings_used);
    $display("%0d gated by the error gate, %0d zeroed by the dead band, %0d mismatches",
             sb.gated_count, sb.deadband_hits, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
